// ----- src/assert_macros.svh -----
// Assertion macros for the UTF-8 decoder RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: invariant violated");

// Condition in this cycle implies a check in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check violated");

`endif

// ----- src/u8d_pkg.sv -----
// Package for the UTF-8 code point decoder: constants and the job word type.
// No dependencies; used by every module of the decoder.
package u8d_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

  // One queued job: rep replacement chars come first, then cp, rep+1 words total.
  typedef struct packed {
    logic [1:0]      rep;
    logic [CP_W-1:0] cp;
    logic            last;
  } job_t;

endpackage

// ----- src/u8d_front.sv -----
// Front end of the UTF-8 decoder: accepts bytes, tracks held sequences,
// and turns accepted bytes into job words. Depends on u8d_pkg.
module u8d_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       string_end,
  output logic                       job_valid,
  output u8d_pkg::job_t              job,
  input  logic                       job_ready
);

  logic [1:0] cnt, cnt_next;
  logic [1:0] need, need_next;
  logic [7:0] held [3];

  logic                        accept;
  logic                        holding;
  logic                        is_cont;
  logic [1:0]                  f_need;
  logic                        f_res;
  logic [u8d_pkg::CP_W-1:0]    f_cp;
  logic [u8d_pkg::CP_W-1:0]    asm_cp;
  logic [u8d_pkg::CP_W-1:0]    chk_cp;
  logic                        res;
  logic [1:0]                  rep;
  logic [u8d_pkg::CP_W-1:0]    job_cp;
  logic                        hold_wr;
  logic [1:0]                  hold_idx;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign holding  = (cnt != 2'd0);
  assign is_cont  = (in_byte[7:6] == 2'b10);

  // Decode of the byte as if nothing were held
  always_comb begin
    f_need = 2'd0;
    f_res  = 1'b1;
    f_cp   = u8d_pkg::REPL_CP;
    if (!in_byte[7]) begin
      f_cp = {13'd0, in_byte};
    end else if (in_byte[7:5] == 3'b110) begin
      f_need = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      f_need = 2'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      f_need = 2'd3;
    end
    // lead byte: held unless the string ends here
    if (f_need != 2'd0) begin
      f_res = string_end;
      f_cp  = u8d_pkg::REPL_CP;
    end
  end

  // Assemble the completed sequence and range check it
  always_comb begin
    unique case (need)
      2'd1:    asm_cp = {10'd0, held[0][4:0], in_byte[5:0]};
      2'd2:    asm_cp = {5'd0, held[0][3:0], held[1][5:0], in_byte[5:0]};
      2'd3:    asm_cp = {held[0][2:0], held[1][5:0], held[2][5:0], in_byte[5:0]};
      default: asm_cp = u8d_pkg::REPL_CP;
    endcase
    if ((asm_cp > u8d_pkg::MAX_CP) ||
        ((asm_cp >= u8d_pkg::SURR_LO) && (asm_cp <= u8d_pkg::SURR_HI))) begin
      chk_cp = u8d_pkg::REPL_CP;
    end else begin
      chk_cp = asm_cp;
    end
  end

  // Job word and next hold state
  always_comb begin
    res       = 1'b0;
    rep       = 2'd0;
    job_cp    = u8d_pkg::REPL_CP;
    cnt_next  = cnt;
    need_next = need;
    hold_wr   = 1'b0;
    hold_idx  = 2'd0;
    if (holding && is_cont) begin
      if (cnt == need) begin
        res       = 1'b1;
        job_cp    = chk_cp;
        cnt_next  = 2'd0;
        need_next = 2'd0;
      end else if (string_end) begin
        // lead, held continuations and this byte each give a replacement
        res       = 1'b1;
        rep       = cnt;
        cnt_next  = 2'd0;
        need_next = 2'd0;
      end else begin
        hold_wr  = 1'b1;
        hold_idx = cnt;
        cnt_next = 2'(cnt + 2'd1);
      end
    end else begin
      // broken sequence flushes held bytes, then the byte is decoded fresh
      if (holding) begin
        res = 1'b1;
        if (f_res) begin
          rep    = cnt;
          job_cp = f_cp;
        end else begin
          rep    = 2'(cnt - 2'd1);
          job_cp = u8d_pkg::REPL_CP;
        end
      end else begin
        res    = f_res;
        job_cp = f_cp;
      end
      if ((f_need != 2'd0) && !string_end) begin
        hold_wr   = 1'b1;
        hold_idx  = 2'd0;
        cnt_next  = 2'd1;
        need_next = f_need;
      end else begin
        cnt_next  = 2'd0;
        need_next = 2'd0;
      end
    end
  end

  assign job_valid = accept && res;
  assign job.rep   = rep;
  assign job.cp    = job_cp;
  assign job.last  = string_end;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      need <= 2'd0;
    end else if (accept) begin
      cnt  <= cnt_next;
      need <= need_next;
    end
  end

  // Held bytes, no reset: read only after written in the same sequence
  always_ff @(posedge clk) begin
    if (accept && hold_wr) begin
      held[hold_idx] <= in_byte;
    end
  end

endmodule

// ----- src/u8d_queue.sv -----
// Job queue between the decoder front end and back end.
// Depends on u8d_pkg and assert_macros.svh.
`include "assert_macros.svh"
module u8d_queue #(
  parameter int unsigned DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  u8d_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output u8d_pkg::job_t pop_data
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8d_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + PW'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + PW'(1));
      end
      if (push && !pop) begin
        count <= CW'(count + CW'(1));
      end else if (pop && !push) begin
        count <= CW'(count - CW'(1));
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_count_inc, clk, rst, push && !pop, count == CW'($past(count) + CW'(1)))
  `ASSERT_ALWAYS(a_empty_ptrs, clk, rst, (count == '0) |-> (wr_ptr == rd_ptr))

endmodule

// ----- src/u8d_back.sv -----
// Back end of the UTF-8 decoder: expands each job word into result words.
// Depends on u8d_pkg.
module u8d_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_valid,
  output logic                    job_ready,
  input  u8d_pkg::job_t           job,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [u8d_pkg::CP_W-1:0] code_point,
  output logic                    run_last,
  output logic                    string_last
);

  logic                     busy;
  logic [1:0]               rem;
  logic [u8d_pkg::CP_W-1:0] cp;
  logic                     last;
  logic                     load;

  // Current job drained once the final word is taken
  assign job_ready = !busy || (out_ready && (rem == 2'd0));
  assign load      = job_valid && job_ready;

  assign out_valid   = busy;
  assign code_point  = (rem != 2'd0) ? u8d_pkg::REPL_CP : cp;
  assign run_last    = (rem == 2'd0);
  assign string_last = (rem == 2'd0) && last;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      rem  <= job.rep;
    end else if (busy && out_ready) begin
      if (rem != 2'd0) begin
        rem <= 2'(rem - 2'd1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // Payload of the current job
  always_ff @(posedge clk) begin
    if (load) begin
      cp   <= job.cp;
      last <= job.last;
    end
  end

endmodule

// ----- src/utf8_codepoint_decoder_top.sv -----
// UTF-8 decoder: one byte accepted per cycle while the job queue has room; results pass the queue and back end.
// A byte yields 0 to 4 words; output runs one word per cycle from the back end while out_ready is high.
// Malformed runs of k words stall input only when the job queue fills up.
// Synchronous active-high reset clears hold state, queue and output; no clear pass.
// Depends on u8d_pkg, u8d_front, u8d_queue, u8d_back.
module utf8_codepoint_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     string_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [u8d_pkg::CP_W-1:0] code_point,
  output logic                     run_last,
  output logic                     string_last
);

  logic          fq_valid, fq_ready;
  u8d_pkg::job_t fq_job;
  logic          qb_valid, qb_ready;
  u8d_pkg::job_t qb_job;

  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .string_end (string_end),
    .job_valid  (fq_valid),
    .job        (fq_job),
    .job_ready  (fq_ready)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  u8d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (qb_valid),
    .job_ready   (qb_ready),
    .job         (qb_job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .run_last    (run_last),
    .string_last (string_last)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for utf8_codepoint_decoder_top: byte stream in, code point words out.
// Mirrors the decoder state to predict every word and compares each word as it is taken.
// Depends on u8d_pkg and the decoder RTL.
module tb_top;

  // One expected or observed output word
  typedef struct packed {
    logic [u8d_pkg::CP_W-1:0] cp;
    logic                     run_last;
    logic                     string_last;
  } cp_word_t;

  localparam int unsigned DRAIN_CYCLES = 8;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               in_byte = 8'h00;
  logic                     string_end = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [u8d_pkg::CP_W-1:0] code_point;
  logic                     run_last;
  logic                     string_last;

  int send_idle_pct = 33;
  int recv_idle_pct = 49;
  int errors = 0;

  // Words still owed by the decoder, oldest first
  cp_word_t pending_words[$];
  // Words caused by the byte being predicted
  cp_word_t byte_words[$];

  // Mirror of the decoder's hold state
  logic [7:0] held_q [0:2];
  logic [1:0] held_cnt = 2'd0;
  logic [1:0] cont_need = 2'd0;

  utf8_codepoint_decoder_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .run_last   (run_last),
    .string_last(string_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each taken word with the oldest prediction
  always @(posedge clk) begin : check_words
    cp_word_t got;
    cp_word_t want;
    got = '{cp: code_point, run_last: run_last, string_last: string_last};
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word cp=%h run_last=%b string_last=%b",
                 $time, got.cp, got.run_last, got.string_last);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected cp=%h rl=%b sl=%b, actual cp=%h rl=%b sl=%b",
                   $time, want.cp, want.run_last, want.string_last,
                   got.cp, got.run_last, got.string_last);
        end
      end
    end
  end

  task automatic add_word(input logic [u8d_pkg::CP_W-1:0] cp);
    byte_words.push_back('{cp: cp, run_last: 1'b0, string_last: 1'b0});
  endtask

  // Decode a byte with nothing held: ASCII, a new lead, or a bad byte
  task automatic start_fresh(input logic [7:0] b, input logic last);
    logic [1:0] need;
    need = 2'd0;
    if (b[7] == 1'b0) add_word({13'd0, b});
    else if (b[7:5] == 3'b110) need = 2'd1;
    else if (b[7:4] == 4'b1110) need = 2'd2;
    else if (b[7:3] == 5'b11110) need = 2'd3;
    else add_word(u8d_pkg::REPL_CP);
    if (need != 2'd0) begin
      if (last) begin
        add_word(u8d_pkg::REPL_CP);
      end else begin
        held_q[0] = b;
        held_cnt = 2'd1;
        cont_need = need;
      end
    end
  endtask

  // Work out the words one accepted byte causes and queue them
  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [u8d_pkg::CP_W-1:0] acc;
    int k;
    byte_words.delete();
    if (held_cnt != 0 && cont_need != 0 && held_cnt <= cont_need) begin
      if (b[7:6] == 2'b10) begin
        if (held_cnt == cont_need) begin
          case (cont_need)
            2'd1: acc = {16'd0, held_q[0][4:0]};
            2'd2: acc = {17'd0, held_q[0][3:0]};
            default: acc = {18'd0, held_q[0][2:0]};
          endcase
          for (k = 1; k < held_cnt; k++) acc = (acc << 6) | held_q[k][5:0];
          acc = (acc << 6) | b[5:0];
          if (acc > u8d_pkg::MAX_CP ||
              (acc >= u8d_pkg::SURR_LO && acc <= u8d_pkg::SURR_HI)) begin
            acc = u8d_pkg::REPL_CP;
          end
          add_word(acc);
          held_cnt = 2'd0;
          cont_need = 2'd0;
        end else if (last) begin
          // string ends mid-sequence: lead, held and current byte all replaced
          for (k = 0; k < held_cnt; k++) add_word(u8d_pkg::REPL_CP);
          add_word(u8d_pkg::REPL_CP);
          held_cnt = 2'd0;
          cont_need = 2'd0;
        end else begin
          held_q[held_cnt] = b;
          held_cnt = held_cnt + 2'd1;
        end
      end else begin
        // broken sequence: flush held bytes, then decode this byte afresh
        for (k = 0; k < held_cnt; k++) add_word(u8d_pkg::REPL_CP);
        held_cnt = 2'd0;
        cont_need = 2'd0;
        start_fresh(b, last);
      end
    end else begin
      held_cnt = 2'd0;
      cont_need = 2'd0;
      start_fresh(b, last);
    end
    if (byte_words.size() > 0) begin
      byte_words[byte_words.size() - 1].run_last = 1'b1;
      byte_words[byte_words.size() - 1].string_last = last;
    end
    foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
  endtask

  // Offer one byte, with random idle cycles first, and wait for the handshake
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    string_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, last);
  endtask

  // Hold off input until every predicted word has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_ascii_passthrough();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // Overlong two-byte, surrogate, highest code point, above range
  task automatic test_multibyte_forms();
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_malformed_sequences();
    // stray continuation and invalid lead bytes
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    // lead byte ends the string
    send_byte(8'hC3, 1'b1);
    // four-byte sequence broken by ASCII: four words from one byte
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b1);
    // string ends on a continuation before the sequence is complete
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Mostly well-formed strings with random payload bits, some truncated or noisy
  task automatic test_random_strings(input int n_bytes);
    logic [7:0] seq_bytes[$];
    int sent;
    int n_chars;
    int n_conts;
    int r;
    sent = 0;
    while (sent < n_bytes) begin
      seq_bytes.delete();
      n_chars = $urandom_range(1, 8);
      repeat (n_chars) begin
        r = $urandom_range(0, 9);
        if (r < 9) begin
          n_conts = $urandom_range(0, 3);
          case (n_conts)
            0: seq_bytes.push_back({1'b0, 7'($urandom_range(0, 127))});
            1: seq_bytes.push_back({3'b110, 5'($urandom_range(0, 31))});
            2: seq_bytes.push_back({4'b1110, 4'($urandom_range(0, 15))});
            default: seq_bytes.push_back({5'b11110, 3'($urandom_range(0, 7))});
          endcase
          // one in nine multi-byte sequences loses continuation bytes
          if (r == 8 && n_conts > 0) n_conts = $urandom_range(0, n_conts - 1);
          repeat (n_conts) seq_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
        end else begin
          seq_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (seq_bytes[i]) send_byte(seq_bytes[i], i == seq_bytes.size() - 1);
      sent += seq_bytes.size();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_ascii_passthrough();
    test_multibyte_forms();
    test_malformed_sequences();
    test_random_strings(45);
    wait_drained();

    send_idle_pct = 49;
    recv_idle_pct = 33;
    test_random_strings(45);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_strings(45);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- utf8_codepoint_decoder_top.f -----
+incdir+src
src/u8d_pkg.sv
src/u8d_front.sv
src/u8d_queue.sv
src/u8d_back.sv
src/utf8_codepoint_decoder_top.sv
tb/tb_top.sv
